[rtl/pcpg_pkg.sv]
// ----------------------------------------------------------------------------
// pcpg_pkg
// Shared types and constants of the polynomial circle point generator.
// ----------------------------------------------------------------------------
package pcpg_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_t;

  // Number of mirrored points per step and the index of the final one.
  localparam int unsigned NUM_OCTANTS = 8;
  localparam logic [2:0]  LAST_OCTANT = 3'd7;

  // Per-octant selection masks, bit k for octant k.
  // x_is_t: the x offset is the root t, else the step index i.
  // x_neg:  the x offset is subtracted from the center.
  localparam logic [NUM_OCTANTS-1:0] X_IS_T = 8'b1010_1010;
  localparam logic [NUM_OCTANTS-1:0] X_NEG  = 8'b1001_1100;
  localparam logic [NUM_OCTANTS-1:0] Y_IS_T = 8'b0101_0101;
  localparam logic [NUM_OCTANTS-1:0] Y_NEG  = 8'b0110_1100;

endpackage

[rtl/polynomial_circle_point_gen.sv]
// The eight results of a step come out on consecutive cycles, after the request has
// passed stages A to C, the square root stages, the serializer and the output register.
// Requests enter the pipeline one per cycle while busy is low; it holds while a finished
// root waits for the serializer to free the single result port. Steps outside the octant
// are dropped at stage C. The receiver cannot stall, so results never wait on it.
// Synchronous reset clears the configuration registers, the pipeline valid bits, the serializer state and the strobe.
// ----------------------------------------------------------------------------
// polynomial_circle_point_gen
// Pipelined circle rasterizer: for a step index i inside the first octant it
// computes t = floor(sqrt(r*r - i*i)) and emits the eight mirrored pixels.
// ----------------------------------------------------------------------------
module polynomial_circle_point_gen
  import pcpg_pkg::*;
#(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request channel.
  input  logic                                  start,
  output logic                                  busy,
  input  logic [RADIUS_BITS-1:0]                step_index,
  // Result channel; the receiver always takes a result in its strobe cycle.
  output logic                                  strobe,
  output logic [COORD_BITS:0]                   pixel_x,
  output logic [COORD_BITS:0]                   pixel_y,
  output logic [2:0]                            octant,
  output logic                                  last_point,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data
);

  localparam int R   = RADIUS_BITS;
  localparam int SQW = 2 * RADIUS_BITS;             // width of squares
  localparam int PW  = RADIUS_BITS + 3;             // partial remainder width
  localparam int PIX = COORD_BITS + 1;              // pixel coordinate width
  localparam int CW  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int SW  = (PIX > RADIUS_BITS) ? PIX : RADIUS_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers. The radius square is formed when the radius is
  // written, so the datapath never multiplies by the radius itself.
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [R-1:0]          radius;
  logic [SQW-1:0]        rsq;
  logic [R-1:0]          cfg_radius;

  assign cfg_ready  = 1'b1;
  assign cfg_radius = cfg_data[R-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
      rsq      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y: center_y <= cfg_data[COORD_BITS-1:0];
        CFG_RADIUS: begin
          radius <= cfg_radius;
          rsq    <= SQW'(cfg_radius) * SQW'(cfg_radius);
        end
        default: ;  // Index three names no register; the write is dropped.
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. The whole pipeline moves together; it holds only when a
  // finished root waits at the head while the serializer still has points of
  // the previous step to send. A request is taken whenever the pipeline moves.
  // --------------------------------------------------------------------------
  logic adv;
  logic ser_active;
  logic [2:0] ser_cnt;
  logic ser_free;
  logic sq_valid [0:R];

  assign ser_free = !ser_active || (ser_cnt == LAST_OCTANT);
  assign adv      = !(sq_valid[R] && !ser_free);
  assign busy     = !adv;

  // Stage A: capture the request.
  logic         a_valid;
  logic [R-1:0] a_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_i <= step_index;
    end
  end

  // Stage B: square the step index and check that the circle fits the screen.
  logic           b_valid;
  logic [R-1:0]   b_i;
  logic [SQW-1:0] b_isq;
  logic           b_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_i    <= a_i;
      b_isq  <= SQW'(a_i) * SQW'(a_i);
      b_fits <= (CW'(radius) <= CW'(center_x)) && (CW'(radius) <= CW'(center_y));
    end
  end

  // Stage C: octant test 2*i*i < r*r and the radicand r*r - i*i. Steps that
  // fail the test or a circle that does not fit are dropped here.
  logic b_inside;
  logic [SQW-1:0] b_rem;

  assign b_inside = ({b_isq, 1'b0} < {1'b0, rsq});
  assign b_rem    = rsq - b_isq;

  logic [R-1:0]   sq_i    [0:R];
  logic [SQW-1:0] sq_v    [0:R];
  logic [PW-1:0]  sq_p    [0:R];
  logic [R-1:0]   sq_root [0:R];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= b_valid && b_fits && b_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_i[0]    <= b_i;
      sq_v[0]    <= b_rem;
      sq_p[0]    <= '0;
      sq_root[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per stage, most significant first. Each stage
  // brings down the next two radicand bits into the partial remainder and
  // subtracts the trial value 4*root + 1 when it fits.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < R; s++) begin : g_sqrt
    logic [PW-1:0] p_shift;
    logic [PW-1:0] trial;
    logic          fits;

    always_comb begin
      p_shift = {sq_p[s][PW-3:0], sq_v[s][SQW-1 -: 2]};
      trial   = {1'b0, sq_root[s], 2'b01};
      fits    = (p_shift >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[s+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[s+1] <= sq_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_i[s+1]    <= sq_i[s];
        sq_v[s+1]    <= {sq_v[s][SQW-3:0], 2'b00};
        sq_p[s+1]    <= fits ? (p_shift - trial) : p_shift;
        sq_root[s+1] <= {sq_root[s][R-2:0], fits};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Serializer: holds one step's root and index and sends the eight mirrored
  // points on consecutive cycles. A new step loads in the cycle the eighth
  // point of the previous one is formed, so full steps come out back to back.
  // --------------------------------------------------------------------------
  logic         ser_load;
  logic [R-1:0] ser_t;
  logic [R-1:0] ser_i;

  assign ser_load = adv && sq_valid[R];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_active <= 1'b0;
      ser_cnt    <= '0;
    end else if (ser_load) begin
      ser_active <= 1'b1;
      ser_cnt    <= '0;
    end else if (ser_active) begin
      ser_cnt <= ser_cnt + 3'd1;
      if (ser_cnt == LAST_OCTANT) begin
        ser_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_t <= sq_root[R];
      ser_i <= sq_i[R];
    end
  end

  // Mirror the offsets for the current octant and place them around the center.
  logic [R-1:0]   off_x;
  logic [R-1:0]   off_y;
  logic [SW-1:0]  sum_x;
  logic [SW-1:0]  sum_y;
  logic [PIX-1:0] px_next;
  logic [PIX-1:0] py_next;

  always_comb begin
    off_x = X_IS_T[ser_cnt] ? ser_t : ser_i;
    off_y = Y_IS_T[ser_cnt] ? ser_t : ser_i;
    sum_x = X_NEG[ser_cnt] ? (SW'(center_x) - SW'(off_x)) : (SW'(center_x) + SW'(off_x));
    sum_y = Y_NEG[ser_cnt] ? (SW'(center_y) - SW'(off_y)) : (SW'(center_y) + SW'(off_y));
    px_next = sum_x[PIX-1:0];
    py_next = sum_y[PIX-1:0];
  end

  // Output register: one point per cycle while the serializer is active, marked by the strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ser_active;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_active) begin
      pixel_x    <= px_next;
      pixel_y    <= py_next;
      octant     <= ser_cnt;
      last_point <= (ser_cnt == LAST_OCTANT);
    end
  end

endmodule
